[rtl/sfir_pkg.sv]
// ----------------------------------------------------------------------------
// sfir_pkg
// Types and fixed widths shared by the symmetric line filter and its cells.
// ----------------------------------------------------------------------------
package sfir_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 16;
   localparam int N_COEF      = 8;
   localparam int CSR_IDX_BITS = 3;
   localparam int PAIR_BITS   = SAMPLE_BITS + 1;
   localparam int PROD_BITS   = PAIR_BITS + COEF_BITS;
   localparam int FRAC_BITS   = 16;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COEF_CENTER = 3'd0,
      CSR_COEF_DIST1  = 3'd1,
      CSR_COEF_DIST2  = 3'd2,
      CSR_COEF_DIST3  = 3'd3,
      CSR_COEF_DIST4  = 3'd4,
      CSR_COEF_DIST5  = 3'd5,
      CSR_COEF_DIST6  = 3'd6,
      CSR_COEF_DIST7  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] pixel_value;
      logic                   line_end;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] filtered_value;
      logic                   line_done;
   } rsp_type;

   // window update control for the tap cells
   typedef struct packed {
      logic shift;
      logic fill;
   } win_ctl_type;

   // token that travels with a sum down the multiply chain
   typedef struct packed {
      logic valid;
      logic done;
   } tok_type;

endpackage

[rtl/sfir_tap_cell.sv]
// ----------------------------------------------------------------------------
// sfir_tap_cell
// One sample of the filter window: loads from its neighbour on a shift, or
// takes the incoming pixel when the line starts.
// ----------------------------------------------------------------------------
module sfir_tap_cell (
   input  logic                               clock,
   input  sfir_pkg::win_ctl_type              ctl,
   input  logic [sfir_pkg::SAMPLE_BITS-1:0]   fill_value,
   input  logic [sfir_pkg::SAMPLE_BITS-1:0]   next_value,
   output logic [sfir_pkg::SAMPLE_BITS-1:0]   sample
);

   logic [sfir_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic [sfir_pkg::SAMPLE_BITS-1:0] sample_in;

   always_comb begin
      sample_in = sample_ff;
      if (ctl.shift) begin
         sample_in = ctl.fill ? fill_value : next_value;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign sample = sample_ff;

endmodule

[rtl/sfir_mac_cell.sv]
// ----------------------------------------------------------------------------
// sfir_mac_cell
// One stage of the multiply chain: weights its own tap pair and adds it to
// the running sum handed on by the previous stage.
// ----------------------------------------------------------------------------
module sfir_mac_cell #(
   parameter int IDX      = 0,
   parameter int NPAIR    = 8,
   parameter int ACC_BITS = 36
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          enable,
   input  sfir_pkg::tok_type                             tok_in,
   input  logic [NPAIR-1:0][sfir_pkg::PAIR_BITS-1:0]     pairs_in,
   input  logic [ACC_BITS-1:0]                           acc_in,
   input  logic [sfir_pkg::COEF_BITS-1:0]                coef,
   output sfir_pkg::tok_type                             tok_out,
   output logic [NPAIR-1:0][sfir_pkg::PAIR_BITS-1:0]     pairs_out,
   output logic [ACC_BITS-1:0]                           acc_out
);

   sfir_pkg::tok_type                            tok_ff;
   logic [NPAIR-1:0][sfir_pkg::PAIR_BITS-1:0]    pairs_ff;
   logic [ACC_BITS-1:0]                          acc_ff;
   logic [sfir_pkg::PROD_BITS-1:0]               prod;
   logic [ACC_BITS-1:0]                          acc_in_sum;

   assign prod       = pairs_in[IDX] * coef;
   assign acc_in_sum = acc_in + ACC_BITS'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (enable) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pairs_ff <= pairs_in;
         acc_ff   <= acc_in_sum;
      end
   end

   assign tok_out   = tok_ff;
   assign pairs_out = pairs_ff;
   assign acc_out   = acc_ff;

endmodule

[rtl/symmetric_fir_line_filter.sv]
// ----------------------------------------------------------------------------
// symmetric_fir_line_filter
// Symmetric FIR over one image line with edge replication at both borders.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data  (pixel, line end)
//   rsp      out        rsp_valid/rsp_stall  rsp_data  (filtered, line done)
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One pixel is taken per cycle while no result is stalled and no flush runs.
// A pixel flagged as line end is followed by HALF_TAPS flush steps in which
// the window shifts in the last pixel and no request is taken.
// A request passes through the window, pair add, HALF_TAPS + 1 multiply
// stages and rounding into the output register.
// A stalled result holds the whole pipeline and stalls requests.
// Synchronous reset restores the coefficients and the start-of-line state.
// ----------------------------------------------------------------------------
module symmetric_fir_line_filter #(
   parameter int HALF_TAPS = 7
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  sfir_pkg::req_type                         req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output sfir_pkg::rsp_type                         rsp_data,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  sfir_pkg::csr_index_type                   csr_index,
   input  logic [sfir_pkg::COEF_BITS-1:0]            csr_wdata
);

   localparam int TAPS     = 2 * HALF_TAPS + 1;
   localparam int NPAIR    = HALF_TAPS + 1;
   localparam int LC_BITS  = $clog2(NPAIR + 1);
   localparam int FC_BITS  = $clog2(HALF_TAPS + 1);
   localparam int ACC_BITS = sfir_pkg::PROD_BITS + $clog2(NPAIR);
   localparam int SUM_BITS = ACC_BITS + 1;
   localparam int RES_BITS = SUM_BITS - sfir_pkg::FRAC_BITS;
   localparam int SB       = sfir_pkg::SAMPLE_BITS;

   // coefficient registers
   logic [sfir_pkg::N_COEF-1:0][sfir_pkg::COEF_BITS-1:0] coef_ff;

   assign csr_ready = 1'b1;

   // centre weight sits in the lowest slot and resets to full scale
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= {{((sfir_pkg::N_COEF - 1) * sfir_pkg::COEF_BITS){1'b0}},
                     {sfir_pkg::COEF_BITS{1'b1}}};
      end else if (csr_valid && csr_ready) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // line control
   logic [LC_BITS-1:0] line_cnt_ff;
   logic [LC_BITS-1:0] line_cnt_in;
   logic [LC_BITS-1:0] line_cnt_inc;
   logic [FC_BITS-1:0] flush_cnt_ff;
   logic [FC_BITS-1:0] flush_cnt_in;
   logic               flush_ff;
   logic               flush_in;
   logic               advance;
   logic               accept;
   logic               flush_step;
   logic               step;
   logic               emit;
   logic               last_flush;
   sfir_pkg::win_ctl_type win_ctl;
   sfir_pkg::tok_type     tok0_ff;
   sfir_pkg::tok_type     tok0_in;

   assign advance    = !(rsp_valid && rsp_stall);
   assign req_stall  = flush_ff || !advance;
   assign accept     = req_valid && !req_stall;
   assign flush_step = flush_ff && advance;
   assign step       = accept || flush_step;
   assign last_flush = flush_step && (flush_cnt_ff == FC_BITS'(HALF_TAPS));

   assign line_cnt_inc = (line_cnt_ff == LC_BITS'(NPAIR)) ? line_cnt_ff
                                                          : line_cnt_ff + 1'b1;
   assign emit = step && (line_cnt_inc == LC_BITS'(NPAIR));

   always_comb begin
      win_ctl.shift = step;
      win_ctl.fill  = accept && (line_cnt_ff == '0);
      line_cnt_in   = line_cnt_ff;
      flush_cnt_in  = flush_cnt_ff;
      flush_in      = flush_ff;
      tok0_in       = tok0_ff;
      if (advance) begin
         tok0_in.valid = emit;
         tok0_in.done  = last_flush;
      end
      if (accept) begin
         line_cnt_in = line_cnt_inc;
         if (req_data.line_end) begin
            flush_in     = 1'b1;
            flush_cnt_in = FC_BITS'(1);
         end
      end else if (flush_step) begin
         if (last_flush) begin
            flush_in    = 1'b0;
            line_cnt_in = '0;
         end else begin
            line_cnt_in  = line_cnt_inc;
            flush_cnt_in = flush_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_cnt_ff  <= '0;
         flush_cnt_ff <= '0;
         flush_ff     <= 1'b0;
         tok0_ff      <= '0;
      end else begin
         line_cnt_ff  <= line_cnt_in;
         flush_cnt_ff <= flush_cnt_in;
         flush_ff     <= flush_in;
         tok0_ff      <= tok0_in;
      end
   end

   // window: row of tap cells, newest sample at the top end
   logic [TAPS-1:0][SB-1:0] win;
   logic [TAPS-1:0][SB-1:0] win_next;

   always_comb begin
      for (int k = 0; k < TAPS - 1; k++) begin
         win_next[k] = win[k+1];
      end
      // during the flush the last pixel is repeated for the right border
      win_next[TAPS-1] = flush_ff ? win[TAPS-1] : req_data.pixel_value;
   end

   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      sfir_tap_cell u_tap (
         .clock      (clock),
         .ctl        (win_ctl),
         .fill_value (req_data.pixel_value),
         .next_value (win_next[k]),
         .sample     (win[k])
      );
   end

   // symmetric pre-add: pair d sums the two samples d away from centre; pair 0 is the centre alone
   logic [NPAIR-1:0][sfir_pkg::PAIR_BITS-1:0] pair_ff;
   logic [NPAIR-1:0][sfir_pkg::PAIR_BITS-1:0] pair_in;
   sfir_pkg::tok_type                         ptok_ff;

   always_comb begin
      pair_in[0] = {1'b0, win[HALF_TAPS]};
      for (int d = 1; d < NPAIR; d++) begin
         pair_in[d] = {1'b0, win[HALF_TAPS-d]} + {1'b0, win[HALF_TAPS+d]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptok_ff <= '0;
      end else if (advance) begin
         ptok_ff <= tok0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff <= pair_in;
      end
   end

   // multiply chain
   sfir_pkg::tok_type                              chain_tok   [NPAIR+1];
   logic [NPAIR-1:0][sfir_pkg::PAIR_BITS-1:0]      chain_pairs [NPAIR+1];
   logic [ACC_BITS-1:0]                            chain_acc   [NPAIR+1];

   assign chain_tok[0]   = ptok_ff;
   assign chain_pairs[0] = pair_ff;
   assign chain_acc[0]   = '0;

   for (genvar d = 0; d < NPAIR; d++) begin : g_mac
      sfir_mac_cell #(
         .IDX      (d),
         .NPAIR    (NPAIR),
         .ACC_BITS (ACC_BITS)
      ) u_mac (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .tok_in    (chain_tok[d]),
         .pairs_in  (chain_pairs[d]),
         .acc_in    (chain_acc[d]),
         .coef      (coef_ff[d]),
         .tok_out   (chain_tok[d+1]),
         .pairs_out (chain_pairs[d+1]),
         .acc_out   (chain_acc[d+1])
      );
   end

   // rounding and saturation into the output register
   logic [SUM_BITS-1:0] round_sum;
   logic [RES_BITS-1:0] round_res;
   logic [SB-1:0]       sat_res;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   sfir_pkg::rsp_type   rsp_data_ff;
   sfir_pkg::rsp_type   rsp_data_in;

   assign round_sum = SUM_BITS'(chain_acc[NPAIR])
                    + SUM_BITS'(1 << (sfir_pkg::FRAC_BITS - 1));
   assign round_res = round_sum[SUM_BITS-1:sfir_pkg::FRAC_BITS];
   assign sat_res   = (round_res[RES_BITS-1:SB] != '0) ? {SB{1'b1}} : round_res[SB-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in               = chain_tok[NPAIR].valid;
         rsp_data_in.filtered_value = sat_res;
         rsp_data_in.line_done      = chain_tok[NPAIR].done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
